FILE: sv/arr_pkg.sv
// ----------------------------------------------------------------------------
// arr_pkg: shared constants of the apparent reproduction ratio engine
// Command codes, register indexes and result widths used by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package arr_pkg;

  localparam logic [1:0] CMD_LOAD_LAG    = 2'd0;
  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_LOAD_OBS    = 2'd2;
  localparam logic [1:0] CMD_COMPUTE     = 2'd3;

  localparam logic [1:0] REG_NUM_TIMES = 2'd0;
  localparam logic [1:0] REG_NUM_SITES = 2'd1;
  localparam logic [1:0] REG_NUM_LAGS  = 2'd2;

  localparam int RATIO_W = 24;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;

  typedef logic [RATIO_W-1:0] ratio_t;

endpackage

`default_nettype wire

FILE: sv/arr_div.sv
// ----------------------------------------------------------------------------
// arr_div: saturating fixed-point ratio divider
// Computes floor(num * 2^16 / den) one quotient bit per cycle, saturating to
// all ones when the ratio is 256 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module arr_div
  import arr_pkg::*;
#(
  parameter int NUM_W = 57,
  parameter int DEN_W = 38
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output ratio_t                quot
);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [7:0]       nlo_r;
  ratio_t           q_r;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   shifted;
  logic             sat;

  assign sat     = {8'd0, num} >= {{(NUM_W-DEN_W){1'b0}}, den, 8'd0};
  assign shifted = {rem_r[DEN_W-1:0], nlo_r[7]};
  assign rem_nxt = (shifted >= {1'b0, den_r}) ? (shifted - {1'b0, den_r}) : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (sat) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      nlo_r <= num[7:0];
      cnt_r <= 5'd24;
      rem_r <= (DEN_W+1)'(num >> 8);
      q_r   <= sat ? RATIO_MAX : '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nlo_r <= {nlo_r[6:0], 1'b0};
      cnt_r <= cnt_r - 5'd1;
      q_r   <= {q_r[RATIO_W-2:0], (shifted >= {1'b0, den_r})};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

FILE: sv/apparent_reproduction_ratio_top.sv
// ----------------------------------------------------------------------------
// apparent_reproduction_ratio_top: apparent reproduction ratio engine
// Holds lag taps, site weights and per-time, per-site rates and counts, and
// answers compute requests with local, imported and apparent ratios.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// in_      slave      load or compute request, command in tuser
// out_     master     ratios of one compute request, undefined flag in tuser
// cfg_     write      num_times, num_sites, num_lags
//
// The duration of a compute request is set by one shared 24x16 multiplier and
// a one-bit-per-cycle divider. A request at time zero skips the site loop, an
// undefined result skips the divisions, and a saturating ratio skips the
// bit-serial division steps.
// Reset clears control state only; tables must be written before use.
// in_tready is low while a request is in work; a result waits in the output
// register until taken.
`default_nettype none

module apparent_reproduction_ratio_top
  import arr_pkg::*;
#(
  parameter int MAX_TIMES = 256,
  parameter int MAX_SITES = 16,
  parameter int MAX_LAG   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // lag_index, time_index, target_site, source_site, weight_value,
  // rate_value, case_count
  input  wire logic [79:0] in_tdata,
  // command
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_time, result_site, ratio_apparent, ratio_local, ratio_import
  output logic [87:0]      out_tdata,
  // undefined_flag
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);

  localparam int NT_W  = $clog2(MAX_TIMES + 1);
  localparam int NS_W  = $clog2(MAX_SITES + 1);
  localparam int NL_W  = $clog2(MAX_LAG + 1);
  localparam int LA_W  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int SW_D  = MAX_SITES * MAX_SITES;
  localparam int SW_W  = (SW_D > 1) ? $clog2(SW_D) : 1;
  localparam int TB_D  = MAX_TIMES * MAX_SITES;
  localparam int TB_W  = $clog2(TB_D);
  localparam int CR_W  = 41 + $clog2(MAX_LAG);
  localparam int CY_W  = 33 + $clog2(MAX_LAG);
  localparam int NUM_W = CR_W + 2 + $clog2(MAX_SITES);
  localparam int NT_RST = (MAX_TIMES < 256) ? MAX_TIMES : 256;
  localparam int NS_RST = (MAX_SITES < 16) ? MAX_SITES : 16;
  localparam int NL_RST = (MAX_LAG < 32) ? MAX_LAG : 32;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_W0   = 4'd5;
  localparam logic [3:0] S_W1   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DST  = 4'd8;
  localparam logic [3:0] S_DWT  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [4:0]  f_lag;
  logic [7:0]  f_time;
  logic [3:0]  f_target, f_source;
  logic [15:0] f_weight, f_count;
  logic [23:0] f_rate;

  assign f_lag    = in_tdata[4:0];
  assign f_time   = in_tdata[12:5];
  assign f_target = in_tdata[16:13];
  assign f_source = in_tdata[20:17];
  assign f_weight = in_tdata[36:21];
  assign f_rate   = in_tdata[60:37];
  assign f_count  = in_tdata[76:61];

  logic [NT_W-1:0] num_times_r;
  logic [NS_W-1:0] num_sites_r;
  logic [NL_W-1:0] num_lags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_times_r <= NT_W'(NT_RST);
      num_sites_r <= NS_W'(NS_RST);
      num_lags_r  <= NL_W'(NL_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_TIMES: begin
          if (cfg_wdata == 9'd0) num_times_r <= NT_W'(1);
          else if (32'(cfg_wdata) > 32'(MAX_TIMES)) num_times_r <= NT_W'(MAX_TIMES);
          else num_times_r <= NT_W'(cfg_wdata);
        end
        REG_NUM_SITES: begin
          if (cfg_wdata[4:0] == 5'd0) num_sites_r <= NS_W'(1);
          else if (32'(cfg_wdata[4:0]) > 32'(MAX_SITES)) num_sites_r <= NS_W'(MAX_SITES);
          else num_sites_r <= NS_W'(cfg_wdata[4:0]);
        end
        REG_NUM_LAGS: begin
          if (cfg_wdata[5:0] == 6'd0) num_lags_r <= NL_W'(1);
          else if (32'(cfg_wdata[5:0]) > 32'(MAX_LAG)) num_lags_r <= NL_W'(MAX_LAG);
          else num_lags_r <= NL_W'(cfg_wdata[5:0]);
        end
        default: begin
        end
      endcase
    end
  end

  logic [15:0] lag_mem  [MAX_LAG];
  logic [15:0] sw_mem   [SW_D];
  logic [23:0] rate_mem [TB_D];
  logic [15:0] cnt_mem  [TB_D];

  logic [3:0]       state_r;
  logic [7:0]       t_r;
  logic [3:0]       row_r;
  logic [NS_W-1:0]  k_r;
  logic [NL_W-1:0]  lag_r, max_l_r;
  logic [CR_W-1:0]  conv_r_r;
  logic [CY_W-1:0]  conv_y_r, den_r;
  logic [NUM_W-1:0] num_loc_r, num_imp_r;
  logic [23:0]      rt_r;
  logic [39:0]      plo_r;
  logic [1:0]       sel_r;
  ratio_t           r_app_r, r_loc_r, r_imp_r;
  logic             undef_r;
  logic             out_valid_r;
  logic [87:0]      out_data_r;
  logic             out_undef_r;

  logic [15:0] tap_rd_r, w_rd_r, cnt_rd_r;
  logic [23:0] rate_rd_r;

  logic        accept;
  logic [31:0] taddr, swaddr, wr_taddr, wr_swaddr;
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic [39:0] mul_p;
  logic [47:0] cr48;
  logic [63:0] wfull;
  logic [NUM_W-1:0] wterm;
  logic [NL_W-1:0]  max_l;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  ratio_t           div_q;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign taddr     = (32'(t_r) - 32'(lag_r)) * 32'(MAX_SITES) + 32'(k_r);
  assign swaddr    = 32'(row_r) * 32'(MAX_SITES) + 32'(k_r);
  assign wr_taddr  = 32'(f_time) * 32'(MAX_SITES) + 32'(f_target);
  assign wr_swaddr = 32'(f_target) * 32'(MAX_SITES) + 32'(f_source);
  assign max_l     = (32'(num_lags_r) < 32'(f_time)) ? num_lags_r : NL_W'(f_time);

  always_ff @(posedge clk) begin
    if (accept) begin
      case (in_tuser)
        CMD_LOAD_LAG: begin
          if (32'(f_lag) < 32'(MAX_LAG)) lag_mem[LA_W'(f_lag)] <= f_weight;
        end
        CMD_LOAD_WEIGHT: begin
          if (32'(f_target) < 32'(MAX_SITES) && 32'(f_source) < 32'(MAX_SITES)) begin
            sw_mem[wr_swaddr[SW_W-1:0]] <= f_weight;
          end
        end
        CMD_LOAD_OBS: begin
          if (32'(f_time) < 32'(MAX_TIMES) && 32'(f_target) < 32'(MAX_SITES)) begin
            rate_mem[wr_taddr[TB_W-1:0]] <= f_rate;
            cnt_mem[wr_taddr[TB_W-1:0]]  <= f_count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tap_rd_r  <= lag_mem[LA_W'(lag_r - NL_W'(1))];
    w_rd_r    <= sw_mem[swaddr[SW_W-1:0]];
    rate_rd_r <= rate_mem[taddr[TB_W-1:0]];
    cnt_rd_r  <= cnt_mem[taddr[TB_W-1:0]];
  end

  assign cr48 = 48'(conv_r_r);

  always_comb begin
    mul_a = rate_rd_r;
    mul_b = tap_rd_r;
    case (state_r)
      S_M2: begin
        mul_a = rt_r;
        mul_b = cnt_rd_r;
      end
      S_M3: begin
        mul_a = {8'd0, cnt_rd_r};
        mul_b = tap_rd_r;
      end
      S_W0: begin
        mul_a = cr48[23:0];
        mul_b = w_rd_r;
      end
      S_W1: begin
        mul_a = cr48[47:24];
        mul_b = w_rd_r;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign wfull = {mul_p, 24'd0} + {24'd0, plo_r};
  assign wterm = NUM_W'(wfull[63:15]);

  always_comb begin
    case (sel_r)
      2'd0:    div_num = num_loc_r + num_imp_r;
      2'd1:    div_num = num_loc_r;
      default: div_num = num_imp_r;
    endcase
  end

  assign div_start = (state_r == S_DST);

  arr_div #(
    .NUM_W(NUM_W),
    .DEN_W(CY_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (den_r),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && in_tuser == CMD_COMPUTE &&
              32'(f_time) < 32'(num_times_r) && 32'(f_target) < 32'(num_sites_r)) begin
            state_r <= (max_l == '0) ? S_FIN : S_RD;
          end
        end
        S_RD: state_r <= S_M1;
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_M3;
        S_M3: state_r <= (lag_r == max_l_r) ? S_W0 : S_RD;
        S_W0: state_r <= S_W1;
        S_W1: state_r <= (k_r == num_sites_r - NS_W'(1)) ? S_FIN : S_RD;
        S_FIN: state_r <= (t_r == 8'd0 || den_r == '0) ? S_OUT : S_DST;
        S_DST: state_r <= S_DWT;
        S_DWT: begin
          if (div_done) state_r <= (sel_r == 2'd2) ? S_OUT : S_DST;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        t_r       <= f_time;
        row_r     <= f_target;
        k_r       <= '0;
        lag_r     <= NL_W'(1);
        max_l_r   <= max_l;
        conv_r_r  <= '0;
        conv_y_r  <= '0;
        num_loc_r <= '0;
        num_imp_r <= '0;
        den_r     <= '0;
        sel_r     <= 2'd0;
      end
      S_M1: rt_r <= mul_p[39:16];
      S_M2: conv_r_r <= conv_r_r + CR_W'(mul_p);
      S_M3: begin
        conv_y_r <= conv_y_r + CY_W'(mul_p);
        if (lag_r != max_l_r) lag_r <= lag_r + NL_W'(1);
      end
      S_W0: plo_r <= mul_p;
      S_W1: begin
        if (32'(k_r) == 32'(row_r)) begin
          num_loc_r <= wterm;
          den_r     <= conv_y_r;
        end else begin
          num_imp_r <= num_imp_r + wterm;
        end
        k_r      <= k_r + NS_W'(1);
        lag_r    <= NL_W'(1);
        conv_r_r <= '0;
        conv_y_r <= '0;
      end
      S_FIN: begin
        undef_r <= (t_r == 8'd0 || den_r == '0);
        r_app_r <= '0;
        r_loc_r <= '0;
        r_imp_r <= '0;
      end
      S_DWT: begin
        if (div_done) begin
          case (sel_r)
            2'd0:    r_app_r <= div_q;
            2'd1:    r_loc_r <= div_q;
            default: r_imp_r <= div_q;
          endcase
          sel_r <= sel_r + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r  <= {4'd0, r_imp_r, r_loc_r, r_app_r, row_r, t_r};
          out_undef_r <= undef_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_undef_r;

endmodule

`default_nettype wire
